FILE: src/u8d_pkg.sv
package u8d_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;
	localparam int unsigned RemW  = 2;

	localparam logic [ByteW-1:0] AsciiMax    = 8'h7f;
	localparam logic [ByteW-1:0] Lead2Min    = 8'hc2;
	localparam logic [ByteW-1:0] Lead2Max    = 8'hdf;
	localparam logic [ByteW-1:0] Lead3Max    = 8'hef;
	localparam logic [ByteW-1:0] Lead4Max    = 8'hf4;
	localparam logic [CpW-1:0]   InvalidCp   = 21'h00003f;

	localparam int unsigned BufDepth = 2;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           truncated;
		logic           last;
	} u8d_result_t;

	typedef struct packed {
		logic [RemW-1:0] bytes_remaining;
		logic [CpW-1:0]  partial_value;
	} u8d_state_t;

endpackage

FILE: src/u8d_step.sv
module u8d_step (
	input  u8d_pkg::u8d_state_t  cur,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_string,
	output u8d_pkg::u8d_state_t  nxt,
	output logic                 res_valid,
	output u8d_pkg::u8d_result_t res
);
	import u8d_pkg::*;

	logic [CpW-1:0] shifted;

	assign shifted = {cur.partial_value[CpW-7:0], data_byte[5:0]};

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '{code_point: '0, truncated: 1'b0, last: end_of_string};
		if (cur.bytes_remaining == '0) begin
			if (data_byte <= AsciiMax) begin
				res_valid       = 1'b1;
				res.code_point  = {{(CpW-ByteW){1'b0}}, data_byte};
			end else if (data_byte < Lead2Min || data_byte > Lead4Max) begin
				res_valid       = 1'b1;
				res.code_point  = InvalidCp;
			end else if (data_byte <= Lead2Max) begin
				nxt.partial_value   = {{(CpW-5){1'b0}}, data_byte[4:0]};
				nxt.bytes_remaining = 2'd1;
			end else if (data_byte <= Lead3Max) begin
				nxt.partial_value   = {{(CpW-4){1'b0}}, data_byte[3:0]};
				nxt.bytes_remaining = 2'd2;
			end else begin
				nxt.partial_value   = {{(CpW-3){1'b0}}, data_byte[2:0]};
				nxt.bytes_remaining = 2'd3;
			end
		end else begin
			nxt.bytes_remaining = cur.bytes_remaining - 2'd1;
			if (cur.bytes_remaining == 2'd1) begin
				res_valid         = 1'b1;
				res.code_point    = shifted;
				nxt.partial_value = '0;
			end else begin
				nxt.partial_value = shifted;
			end
		end
		// string ended with a sequence still open
		if (!res_valid && end_of_string) begin
			res_valid = 1'b1;
			res       = '{code_point: '0, truncated: 1'b1, last: 1'b1};
			nxt       = '0;
		end
	end

endmodule

FILE: src/u8d_out_buf.sv
module u8d_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  u8d_pkg::u8d_result_t wr_data,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output u8d_pkg::u8d_result_t rd_data
);
	import u8d_pkg::*;

	u8d_result_t mem_q [BufDepth];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/utf8_stream_decoder_core.sv
// an accepted byte is registered, decoded combinationally and its code point buffered for output
// throughput: one byte per cycle (input register, two-beat output buffer) if beats find room
// only a sequence's final byte gives its beat; a string end inside one gives a truncated beat
// reset clears the decode state, the input stage and the output buffer
module utf8_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        truncated,
	output logic        last
);
	import u8d_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	u8d_state_t  state_q;
	u8d_state_t  state_nxt;
	logic        res_valid;
	u8d_result_t res;
	logic        buf_ready;
	logic        advance;
	u8d_result_t out_data;

	assign advance  = valid_s1 && (!res_valid || buf_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	u8d_step u_step (
		.cur           (state_q),
		.data_byte     (byte_s1),
		.end_of_string (eos_s1),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	u8d_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (valid_s1 && res_valid),
		.wr_ready (buf_ready),
		.wr_data  (res),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_data  (out_data)
	);

	assign code_point = out_data.code_point;
	assign truncated  = out_data.truncated;
	assign last       = out_data.last;

endmodule
